FILE: rtl/core/u8u16_pkg.sv
// Shared types, constants and helpers for the UTF-8 to UTF-16 converter.
// No dependencies; every other file in rtl/core imports this package.
package u8u16_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam int CP_W     = 21;
    localparam int UNIT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int CNTF_W   = 16;

    localparam logic [STATUS_W-1:0] ST_UNIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SURROGATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERLONG  = 3'd4;

    localparam logic [CP_W-1:0]   CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0]   CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0]   CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0]   CP_ASCII_TOP = 21'h000080;
    localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // One decoded result waiting for the output side.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CP_W-1:0]     cp;
        logic [CNTF_W-1:0]   count;
    } t_entry;

    function automatic logic [CNTF_W-1:0] count_field(input t_count cnt);
        return CNTF_W'(cnt);
    endfunction

endpackage

FILE: rtl/core/u8u16_queue.sv
// Short FIFO of decoded results between the decoder front and the encoder back.
// Depends on u8u16_pkg.
module u8u16_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8u16_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output u8u16_pkg::t_entry o_entry
);
    import u8u16_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QAW:0]     r_fill;

    assign o_full  = (r_fill == (QAW+1)'(QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) r_fill <= r_fill + 1'b1;
            else if (!i_push && i_pop) r_fill <= r_fill - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");

    a_fill_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("queue fill count lost a push");

endmodule

FILE: rtl/core/u8u16_front.sv
// Decoder front: takes UTF-8 bytes, tracks the open sequence, validates and
// pushes one finished code point or status per result. Depends on u8u16_pkg.
module u8u16_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    output u8u16_pkg::t_entry o_entry
);
    import u8u16_pkg::*;

    logic [1:0]      r_rem, n_rem;
    logic [CP_W-1:0] r_cp, n_cp;
    logic            r_multi, n_multi;
    logic            r_disc, n_disc;
    t_count          r_cnt, n_cnt;

    logic            push;
    t_entry          entry;

    always_comb begin
        logic [CP_W-1:0] cpn;
        t_count          cnt_inc;
        n_rem   = r_rem;
        n_cp    = r_cp;
        n_multi = r_multi;
        n_disc  = r_disc;
        n_cnt   = r_cnt;
        push    = 1'b0;
        cpn     = {r_cp[CP_W-7:0], i_byte[5:0]};
        cnt_inc = (r_cnt != '1) ? t_count'(r_cnt + 1'b1) : r_cnt;
        entry.status = ST_UNIT;
        entry.cp     = '0;
        entry.count  = count_field(r_cnt);

        if (r_disc) begin
            if (i_byte == '0) begin
                n_disc = 1'b0;
                n_cnt  = '0;
            end
        end else if (r_rem != 2'd0) begin
            push = 1'b1;
            if (i_byte == '0) begin
                // A zero inside a sequence both flags it and ends the string.
                entry.status = ST_INVALID;
                n_rem = '0; n_cp = '0; n_multi = 1'b0;
                n_cnt = '0;
            end else if (i_byte[7:6] != 2'b10) begin
                entry.status = ST_INVALID;
                n_rem = '0; n_cp = '0; n_multi = 1'b0;
                n_disc = 1'b1;
            end else if (r_rem != 2'd1) begin
                push  = 1'b0;
                n_cp  = cpn;
                n_rem = r_rem - 1'b1;
            end else begin
                n_rem = '0; n_cp = '0; n_multi = 1'b0;
                priority if (cpn > CP_MAX) begin
                    entry.status = ST_INVALID;
                    n_disc = 1'b1;
                end else if (cpn >= CP_SURR_LO && cpn <= CP_SURR_HI) begin
                    entry.status = ST_SURROGATE;
                    n_disc = 1'b1;
                end else if (cpn < CP_ASCII_TOP && r_multi) begin
                    entry.status = ST_OVERLONG;
                    n_disc = 1'b1;
                end else begin
                    if (r_multi) n_cnt = cnt_inc;
                    entry.cp    = cpn;
                    entry.count = count_field(r_multi ? cnt_inc : r_cnt);
                end
            end
        end else begin
            priority if (i_byte == '0) begin
                push = 1'b1;
                entry.status = ST_END;
                n_cnt = '0;
            end else if (!i_byte[7]) begin
                push = 1'b1;
                entry.cp = CP_W'(i_byte);
            end else if (i_byte[7:5] == 3'b110) begin
                n_cp = CP_W'(i_byte[4:0]); n_rem = 2'd1; n_multi = 1'b1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_cp = CP_W'(i_byte[3:0]); n_rem = 2'd2; n_multi = 1'b1;
            end else if (i_byte[7:3] == 5'b11110 && i_byte[2:0] <= 3'd5) begin
                n_cp = CP_W'(i_byte[2:0]); n_rem = 2'd3; n_multi = 1'b1;
            end else begin
                push = 1'b1;
                entry.status = ST_INVALID;
                n_disc = 1'b1;
            end
        end
    end

    assign o_push  = i_accept && push;
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_cp    <= '0;
            r_multi <= 1'b0;
            r_disc  <= 1'b0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_rem   <= n_rem;
            r_cp    <= n_cp;
            r_multi <= n_multi;
            r_disc  <= n_disc;
            r_cnt   <= n_cnt;
        end
    end

    a_disc_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> (r_rem == 2'd0 && !r_multi))
        else $error("discarding with an open sequence");

    a_rem_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 2'd0) |-> r_multi)
        else $error("open sequence without multibyte flag");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.status == ST_END) |=> (r_cnt == '0))
        else $error("count not cleared at end of string");

endmodule

FILE: rtl/core/u8u16_back.sv
// Encoder back: turns queued code points into UTF-16 beats, splitting a
// supplementary code point into a surrogate pair. Depends on u8u16_pkg.
module u8u16_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  u8u16_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [31:0]      o_m_tdata,   // [15:0] code_unit, [31:16] multibyte_count
    output logic [2:0]       o_m_tuser,   // [2:0] status
    output logic             o_m_tlast    // last_of_run
);
    import u8u16_pkg::*;

    logic                r_valid;
    logic                r_second;
    logic [UNIT_W-1:0]   r_unit;
    logic [STATUS_W-1:0] r_status;
    logic [CNTF_W-1:0]   r_count;
    logic                r_last;

    logic                is_pair;
    logic [19:0]         offs;
    logic [UNIT_W-1:0]   hi_unit, lo_unit;
    logic                load;

    assign is_pair = (i_entry.status == ST_UNIT) && (i_entry.cp[CP_W-1:16] != '0);
    assign offs    = i_entry.cp[19:0] - 20'h10000;
    assign hi_unit = HI_SURR_BASE + UNIT_W'(offs[19:10]);
    assign lo_unit = LO_SURR_BASE + UNIT_W'(offs[9:0]);
    assign load    = i_valid && (!r_valid || i_m_tready);
    assign o_pop   = load && (!is_pair || r_second);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_entry.status;
            r_count  <= i_entry.count;
            if (is_pair && !r_second) begin
                r_unit <= hi_unit;
                r_last <= 1'b0;
            end else if (is_pair) begin
                r_unit <= lo_unit;
                r_last <= 1'b1;
            end else begin
                r_unit <= i_entry.cp[UNIT_W-1:0];
                r_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= is_pair && !r_second;
            end else if (i_m_tready) begin
                r_valid  <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_count, r_unit};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    a_second_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && !r_last))
        else $error("second surrogate pending without a first beat");

    a_high_surrogate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |->
            (r_status == ST_UNIT && r_unit[15:10] == 6'b110110))
        else $error("non-final beat is not a high surrogate");

    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last && i_m_tready) |=>
            (r_valid && r_last && r_unit[15:10] == 6'b110111))
        else $error("high surrogate not followed by low surrogate");

endmodule

FILE: rtl/core/utf8_to_utf16_converter.sv
// UTF-8 to UTF-16 converter: one byte per beat in, one UTF-16 unit per beat out.
// Each accepted byte's result is written into the result queue, then into the output register.
// Throughput: one byte per cycle while the queue has room; a surrogate pair takes two
// output beats; a 4-entry result queue absorbs those extra beats before input stalls.
// Reset (i_rst_n low, synchronous) closes any open sequence, clears the count
// and empties the queue. Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
module utf8_to_utf16_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] code_unit, [31:16] multibyte_count
    output logic [2:0]  o_m_tuser,   // [2:0] status
    output logic        o_m_tlast    // last_of_run
);
    import u8u16_pkg::*;

    logic   accept;
    logic   push, full, pop, q_valid;
    t_entry push_entry, head_entry;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && o_s_tready;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    u8u16_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .o_full   (full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_entry  (head_entry)
    );

    u8u16_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for utf8_to_utf16_converter: drives UTF-8 strings byte by byte,
// predicts every UTF-16 beat in-line and compares each output beat in order.
// Depends on u8u16_pkg and the converter RTL only.
module tb;
    import u8u16_pkg::*;

    localparam logic [CP_W-1:0] PAIR_BASE      = 21'h010000;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              DRAIN_CYCLES   = 20;
    localparam int              REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [STATUS_W-1:0] status;
        logic [CNTF_W-1:0]   count;
        logic                last;
    } t_utf16_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;    // [7:0] text_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    logic [31:0] o_m_tdata;            // [15:0] code_unit, [31:16] multibyte_count
    logic [2:0]  o_m_tuser;            // [2:0] status
    logic        o_m_tlast;            // last_of_run

    utf8_to_utf16_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Decoder state mirrored from the block.
    logic [1:0]             cont_left = '0;
    logic [CP_W-1:0]        cp_accum = '0;
    logic                   in_multi = 1'b0;
    logic                   skipping = 1'b0;
    logic [COUNT_WIDTH-1:0] seq_count = '0;

    t_utf16_beat expected_units[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int pairs_seen = 0;
    int errors_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    function automatic void push_unit(input logic [UNIT_W-1:0] unit,
                                      input logic [STATUS_W-1:0] status,
                                      input logic last);
        t_utf16_beat beat;
        beat.unit   = unit;
        beat.status = status;
        beat.count  = CNTF_W'(seq_count);
        beat.last   = last;
        expected_units.push_back(beat);
    endfunction

    function automatic void drop_sequence();
        cont_left = '0;
        cp_accum  = '0;
        in_multi  = 1'b0;
    endfunction

    function automatic void reject_sequence(input logic [STATUS_W-1:0] status);
        push_unit('0, status, 1'b1);
        drop_sequence();
        skipping = 1'b1;
    endfunction

    // Works out the beats one accepted byte causes and advances the mirror state.
    function automatic void predict_units(input logic [7:0] b);
        logic [CP_W-1:0] cp;
        logic            multi;
        if (skipping) begin
            if (b == 8'h00) begin
                skipping  = 1'b0;
                seq_count = '0;
            end
            return;
        end
        if (cont_left != 0) begin
            // A zero inside a sequence ends the string without a discard.
            if (b == 8'h00) begin
                push_unit('0, ST_INVALID, 1'b1);
                drop_sequence();
                seq_count = '0;
                return;
            end
            if (b < 8'h80 || b > 8'hBF) begin
                reject_sequence(ST_INVALID);
                return;
            end
            cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 0)
                return;
            cp    = cp_accum;
            multi = in_multi;
            if (cp > CP_MAX)
                reject_sequence(ST_INVALID);
            else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                reject_sequence(ST_SURROGATE);
            else if (cp < CP_ASCII_TOP && multi)
                reject_sequence(ST_OVERLONG);
            else begin
                drop_sequence();
                if (multi && seq_count != '1)
                    seq_count = seq_count + 1'b1;
                if (cp < PAIR_BASE)
                    push_unit(cp[UNIT_W-1:0], ST_UNIT, 1'b1);
                else begin
                    cp = cp - PAIR_BASE;
                    push_unit(HI_SURR_BASE + UNIT_W'(cp[19:10]), ST_UNIT, 1'b0);
                    push_unit(LO_SURR_BASE + UNIT_W'(cp[9:0]), ST_UNIT, 1'b1);
                end
            end
            return;
        end
        if (b == 8'h00) begin
            push_unit('0, ST_END, 1'b1);
            seq_count = '0;
        end else if (b < 8'h80) begin
            push_unit(UNIT_W'(b), ST_UNIT, 1'b1);
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
            cp_accum  = CP_W'(b[4:0]);
            cont_left = 2'd1;
            in_multi  = 1'b1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            cp_accum  = CP_W'(b[3:0]);
            cont_left = 2'd2;
            in_multi  = 1'b1;
        end else if (b >= 8'hF0 && b <= 8'hF5) begin
            cp_accum  = CP_W'(b[2:0]);
            cont_left = 2'd3;
            in_multi  = 1'b1;
        end else begin
            reject_sequence(ST_INVALID);
        end
    endfunction

    // Presents one byte and holds it until the block takes it. tvalid stays high
    // afterwards unless the sender idles, so back-to-back bytes follow without a gap.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = 8'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1)
            @(posedge i_clk);
        predict_units(b);
        bytes_sent++;
    endtask

    // Encodes a code point into len bytes; lengths above the minimum give overlong forms.
    task automatic send_code_point(input logic [CP_W-1:0] cp, input int len);
        logic [7:0] lead;
        case (len)
            1: lead = {1'b0, cp[6:0]};
            2: lead = {3'b110, cp[10:6]};
            3: lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        send_byte(lead);
        for (int k = len - 2; k >= 0; k--)
            send_byte({2'b10, 6'(cp >> (6 * k))});
    endtask

    always @(negedge i_clk)
        i_m_tready = ($urandom_range(99) >= receiver_stall_pct);

    task automatic report_mismatch(input string why, input t_utf16_beat want,
                                   input t_utf16_beat got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display({"MISMATCH %s: expected unit %h status %0d count %0d last %b,",
                      " got unit %h status %0d count %0d last %b"},
                     why, want.unit, want.status, want.count, want.last,
                     got.unit, got.status, got.count, got.last);
    endtask

    always @(posedge i_clk) begin : check_beats
        t_utf16_beat got;
        t_utf16_beat want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got.unit   = o_m_tdata[15:0];
            got.status = o_m_tuser;
            got.count  = o_m_tdata[31:16];
            got.last   = o_m_tlast;
            beats_checked++;
            if (expected_units.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, got);
            end else begin
                want = expected_units.pop_front();
                if (want.status != ST_UNIT && want.status != ST_END)
                    errors_seen++;
                if (!want.last)
                    pairs_seen++;
                if (got.unit !== want.unit)
                    report_mismatch("code_unit", want, got);
                else if (got.status !== want.status)
                    report_mismatch("status", want, got);
                else if (got.count !== want.count)
                    report_mismatch("multibyte_count", want, got);
                else if (got.last !== want.last)
                    report_mismatch("tlast", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic test_ascii_and_terminator();
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    // Shortest and longest values of each multibyte sequence length, including a pair at
    // both ends of the supplementary range.
    task automatic test_valid_sequences();
        send_code_point(21'h000080, 2);
        send_code_point(21'h0007FF, 2);
        send_code_point(21'h000800, 3);
        send_code_point(21'h00FFFF, 3);
        send_code_point(21'h010000, 4);
        send_code_point(21'h10FFFF, 4);
        send_byte(8'h00);
    endtask

    task automatic test_decode_errors();
        send_code_point(21'h000000, 2);      // overlong, then a byte that is skipped
        send_byte(8'h41);
        send_byte(8'h00);
        send_code_point(21'h00007F, 4);      // overlong in four bytes
        send_byte(8'h00);
        send_code_point(CP_SURR_LO, 3);
        send_byte(8'h00);
        send_code_point(CP_SURR_HI, 3);
        send_byte(8'h00);
        send_code_point(21'h110000, 4);      // just past the last code point
        send_byte(8'h00);
        send_byte(8'hF5);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h80);                    // stray continuation as lead
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hC2);                    // ASCII where a continuation belongs
        send_byte(8'h41);
        send_byte(8'h00);
        // A zero inside a sequence ends the string; the next byte is decoded.
        send_code_point(21'h0000E9, 2);
        send_byte(8'hE2);
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h00);
    endtask

    // A long string of two-byte sequences makes the count climb; the next
    // string starts again from zero.
    task automatic test_count_accumulation();
        for (int k = 0; k < 48; k++) begin
            send_byte(8'hC2);
            send_byte(8'h80);
        end
        send_byte(8'h00);
        send_code_point(21'h000100, 2);
        send_byte(8'h00);
    endtask

    // Starts a sequence and gives it only some of its continuation bytes.
    task automatic send_partial_sequence(output int total);
        total = $urandom_range(4, 2);
        case (total)
            2: send_byte(8'($urandom_range(8'hDF, 8'hC2)));
            3: send_byte(8'($urandom_range(8'hEF, 8'hE0)));
            default: send_byte(8'($urandom_range(8'hF4, 8'hF0)));
        endcase
        repeat ($urandom_range(total - 2, 0))
            send_byte(8'($urandom_range(8'hBF, 8'h80)));
    endtask

    // Mostly well-formed strings, with a sprinkling of every kind of damage.
    task automatic send_random_string();
        int n_items;
        int pick;
        int total;
        n_items = $urandom_range(12, 1);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                send_byte(8'($urandom_range(8'h7F, 8'h01)));
            else if (pick < 55)
                send_code_point(CP_W'($urandom_range(16'h07FF, 16'h0080)), 2);
            else if (pick < 69)
                send_code_point(CP_W'($urandom_range(16'hFFFF, 16'h0800)), 3);
            else if (pick < 82)
                send_code_point(CP_W'($urandom_range(21'h10FFFF, 21'h010000)), 4);
            else if (pick < 86)
                send_code_point(CP_W'($urandom_range(8'h7F, 8'h00)), $urandom_range(4, 2));
            else if (pick < 88)
                send_code_point(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
            else if (pick < 91)
                send_code_point(CP_W'($urandom_range(CP_SURR_HI, CP_SURR_LO)), 3);
            else if (pick < 94)
                send_byte(8'($urandom_range(8'hFF, 8'h01)));
            else if (pick < 97) begin
                send_partial_sequence(total);
                if ($urandom_range(1))
                    send_byte(8'($urandom_range(8'h7F, 8'h01)));
                else
                    send_byte(8'($urandom_range(8'hFF, 8'hC0)));
            end else begin
                // Truncated by a zero, which also closes the string.
                send_partial_sequence(total);
                send_byte(8'h00);
                return;
            end
        end
        send_byte(8'h00);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        int stop_at;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_string();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ascii_and_terminator();
        test_valid_sequences();
        test_decode_errors();
        test_count_accumulation();
        test_random_traffic(0, 0, 135);
        test_random_traffic(81, 0, 135);
        test_random_traffic(0, 81, 135);
        test_random_traffic(37, 37, 135);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        receiver_stall_pct = 0;
        while (expected_units.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_units.size() != 0) begin
            mismatch_count++;
            $display("%0d expected beats never arrived", expected_units.size());
        end
        $display("Sent %0d bytes and checked %0d output beats,", bytes_sent, beats_checked);
        $display("among them %0d surrogate pairs and %0d error reports.",
                 pairs_seen, errors_seen);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_queue.sv
rtl/core/u8u16_front.sv
rtl/core/u8u16_back.sv
rtl/core/utf8_to_utf16_converter.sv
tb/sv/tb.sv
